// File: src/pcadj_pkg.sv
// Package for the palette color adjust and pack block.
// Holds the payload and configuration types, register indexes and arithmetic constants.
// No dependencies.
package pcadj_pkg;

   // Arithmetic constants
   localparam int ADJ_DIVISOR   = 30000;
   localparam int BRIGHT_SCALE  = 6400;
   localparam int CHAN_MAX      = 63;
   localparam int PERCENT_UNITY = 100;

   // Width of the signed sum before the divide
   localparam int T_WIDTH = 28;

   // Quotient of t by the divisor: floor(t * RECIP_MULT >> RECIP_SHIFT), exact for t < 2^21
   localparam int     RECIP_SHIFT = 36;
   localparam longint RECIP_FULL  = ((64'd1 << RECIP_SHIFT) + ADJ_DIVISOR - 1) / ADJ_DIVISOR;
   localparam logic [21:0] RECIP_MULT = 22'(RECIP_FULL);

   // Smallest t that clamps to full scale
   localparam logic [T_WIDTH-1:0] CLAMP_LIMIT = T_WIDTH'((CHAN_MAX + 1) * ADJ_DIVISOR);

   // Brightness weight per unit
   localparam logic signed [15:0] BRIGHT_MULT = 16'(BRIGHT_SCALE * 3);
   localparam logic [14:0]        UNITY_MULT  = 15'(PERCENT_UNITY);

   // Register indexes
   localparam logic [1:0] REG_SATURATION = 2'd0;
   localparam logic [1:0] REG_CONTRAST   = 2'd1;
   localparam logic [1:0] REG_BRIGHTNESS = 2'd2;
   localparam logic [1:0] REG_FORMAT     = 2'd3;

   // Pixel formats
   localparam logic FMT_RGB555 = 1'b0;
   localparam logic FMT_RGB565 = 1'b1;

   // Reset values
   localparam logic [7:0] SATURATION_RESET = 8'd100;
   localparam logic [7:0] CONTRAST_RESET   = 8'd100;
   localparam logic [7:0] BRIGHTNESS_RESET = 8'd0;

   typedef struct packed {
      logic [7:0] entry_index;
      logic [5:0] red_in;
      logic [5:0] green_in;
      logic [5:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  entry_out;
      logic [15:0] pixel_word;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]        saturation_percent;
      logic [7:0]        contrast_percent;
      logic signed [7:0] brightness_offset;
      logic              pixel_format;
   } cfg_type;

   // Load enables of the four arithmetic stages
   typedef struct packed {
      logic en_a;
      logic en_b;
      logic en_c;
      logic en_d;
   } stage_ctl_type;

endpackage

// File: src/pcadj_csr.sv
// Configuration registers of the palette color adjust block.
// Depends on pcadj_pkg for register indexes, reset values and cfg_type.
module pcadj_csr
   import pcadj_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SATURATION: cfg_in.saturation_percent = csr_wdata;
            REG_CONTRAST:   cfg_in.contrast_percent   = csr_wdata;
            REG_BRIGHTNESS: cfg_in.brightness_offset  = csr_wdata;
            REG_FORMAT:     cfg_in.pixel_format       = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.saturation_percent <= SATURATION_RESET;
         cfg_ff.contrast_percent   <= CONTRAST_RESET;
         cfg_ff.brightness_offset  <= BRIGHTNESS_RESET;
         cfg_ff.pixel_format       <= FMT_RGB565;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/pcadj_chan.sv
// Four-stage arithmetic pipeline for one color channel.
// Depends on pcadj_pkg for constants, cfg_type and stage_ctl_type.
module pcadj_chan
   import pcadj_pkg::*;
(
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  cfg_type       cfg,
   input  logic [5:0]    chan,
   input  logic [7:0]    vsum,
   output logic [5:0]    level
);

   logic signed [9:0]         diff_ff,  diff_in;
   logic [14:0]               v100_ff,  v100_in;
   logic signed [18:0]        sum_ff,   sum_in;
   logic signed [T_WIDTH-1:0] t_ff,     t_in;
   logic                      neg_ff,   neg_in;
   logic                      big_ff,   big_in;
   logic [20:0]               tlo_ff,   tlo_in;
   logic signed [18:0]        sat_prod;
   logic signed [T_WIDTH-1:0] con_prod;
   logic signed [23:0]        bright_prod;
   logic [7:0]                chan_x3;
   logic [42:0]               recip_prod;

   // Stage A: 3c - v and 100v
   always_comb begin
      chan_x3 = 8'({2'b00, chan} + {1'b0, chan, 1'b0});
      diff_in = $signed({2'b00, chan_x3}) - $signed({2'b00, vsum});
      v100_in = 15'({7'd0, vsum} * UNITY_MULT);
   end

   // Stage B: saturation scaling, operands widened to the product width
   always_comb begin
      sat_prod = $signed(19'(diff_ff)) * $signed({11'd0, cfg.saturation_percent});
      sum_in   = sat_prod + $signed({4'b0000, v100_ff});
   end

   // Stage C: contrast scaling plus brightness, operands widened to the product width
   always_comb begin
      con_prod    = $signed(T_WIDTH'(sum_ff)) * $signed({20'd0, cfg.contrast_percent});
      bright_prod = $signed(24'($signed(cfg.brightness_offset))) * $signed(24'(BRIGHT_MULT));
      t_in        = con_prod + T_WIDTH'(bright_prod);
   end

   // Stage D: clamp classification
   always_comb begin
      neg_in = t_ff[T_WIDTH-1];
      big_in = !t_ff[T_WIDTH-1] && (t_ff >= $signed(CLAMP_LIMIT));
      tlo_in = t_ff[20:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en_a) begin
         diff_ff <= diff_in;
         v100_ff <= v100_in;
      end
      if (ctl.en_b) begin
         sum_ff <= sum_in;
      end
      if (ctl.en_c) begin
         t_ff <= t_in;
      end
      if (ctl.en_d) begin
         neg_ff <= neg_in;
         big_ff <= big_in;
         tlo_ff <= tlo_in;
      end
   end

   // Divide by reciprocal, then clamp
   always_comb begin
      recip_prod = {22'd0, tlo_ff} * {21'd0, RECIP_MULT};
      if (neg_ff) begin
         level = 6'd0;
      end else if (big_ff) begin
         level = 6'(CHAN_MAX);
      end else begin
         level = recip_prod[RECIP_SHIFT+5:RECIP_SHIFT];
      end
   end

endmodule

// File: src/palette_color_adjust_pack_unit.sv
// Palette entries enter one per clock while req_stall is low and come out as packed
// display words through four arithmetic stages (difference, saturation multiply,
// contrast multiply with brightness, clamp test) and a registered output stage where
// the reciprocal divide by 30000 and the RGB555/RGB565 packing happen. Each stage
// holds its own valid bit, so a stall on the result side only backs up as far as the
// pipeline is full; req_stall rises once every stage holds a transaction and the
// output is stalled.
// Depends on pcadj_pkg, pcadj_csr and pcadj_chan.
module palette_color_adjust_pack_unit
   import pcadj_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_wdata
);

   cfg_type         cfg;
   stage_ctl_type   ctl;
   logic [3:0]      valid_ff, valid_in;
   logic [3:0]      en;
   logic            out_en;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic [7:0]      entry_ff [4];
   logic [7:0]      vsum;
   logic [5:0]      red_lvl, green_lvl, blue_lvl;

   pcadj_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Stage enables: a stage loads when empty or when its content moves on
   always_comb begin
      out_en = !rsp_valid_ff || !rsp_stall;
      en[3]  = !valid_ff[3] || out_en;
      en[2]  = !valid_ff[2] || en[3];
      en[1]  = !valid_ff[1] || en[2];
      en[0]  = !valid_ff[0] || en[1];
      ctl.en_a = en[0];
      ctl.en_b = en[1];
      ctl.en_c = en[2];
      ctl.en_d = en[3];
   end

   assign req_stall = !en[0];

   // Valid bits travel with the data
   always_comb begin
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (en[0]) valid_in[0] = req_valid;
      if (en[1]) valid_in[1] = valid_ff[0];
      if (en[2]) valid_in[2] = valid_ff[1];
      if (en[3]) valid_in[3] = valid_ff[2];
      if (out_en) rsp_valid_in = valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Entry number rides alongside the arithmetic
   always_ff @(posedge clock) begin
      if (en[0]) entry_ff[0] <= req_payload.entry_index;
      if (en[1]) entry_ff[1] <= entry_ff[0];
      if (en[2]) entry_ff[2] <= entry_ff[1];
      if (en[3]) entry_ff[3] <= entry_ff[2];
   end

   // Channel sum shared by all three channels
   assign vsum = 8'({2'b00, req_payload.red_in} + {2'b00, req_payload.green_in}
                    + {2'b00, req_payload.blue_in});

   pcadj_chan u_red (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg),
      .chan  (req_payload.red_in),
      .vsum  (vsum),
      .level (red_lvl)
   );

   pcadj_chan u_green (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg),
      .chan  (req_payload.green_in),
      .vsum  (vsum),
      .level (green_lvl)
   );

   pcadj_chan u_blue (
      .clock (clock),
      .ctl   (ctl),
      .cfg   (cfg),
      .chan  (req_payload.blue_in),
      .vsum  (vsum),
      .level (blue_lvl)
   );

   // Pack by pixel format
   always_comb begin
      rsp_payload_in.entry_out = entry_ff[3];
      case (cfg.pixel_format)
         FMT_RGB565: rsp_payload_in.pixel_word = {red_lvl[5:1], green_lvl, blue_lvl[5:1]};
         FMT_RGB555: rsp_payload_in.pixel_word =
            {1'b0, red_lvl[5:1], green_lvl[5:1], blue_lvl[5:1]};
         default:    rsp_payload_in.pixel_word = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
